### src/stip_pkg.sv
// Shared types and character constants for the string-to-integer parser.
package stip_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       new_string;
    logic [4:0] base_request;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] parsed_value;
    logic [15:0]        chars_used;
  } out_item_t;

  // Character as classified by the front end.
  typedef struct packed {
    logic       new_string;
    logic [4:0] base_request;
    logic       digit_ok;
    logic [3:0] digit;
    logic       is_space;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
  } chr_info_t;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  localparam int FQ_PTR_BITS = 2;
  localparam int FQ_DEPTH    = 1 << FQ_PTR_BITS;
  localparam int RQ_PTR_BITS = 1;
  localparam int RQ_DEPTH    = 1 << RQ_PTR_BITS;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  localparam logic [4:0] BASE_DETECT = 5'd0;
  localparam logic [4:0] BASE_OCT    = 5'd8;
  localparam logic [4:0] BASE_DEC    = 5'd10;
  localparam logic [4:0] BASE_HEX    = 5'd16;

endpackage

### src/stip_front.sv
// Front end: classifies each incoming character and queues it for the parse engine.
module stip_front (
  input  logic                clk,
  input  logic                rst_n,
  input  stip_pkg::in_item_t  in_item,
  input  logic                push,
  output logic                full,
  output stip_pkg::chr_info_t q_head,
  output logic                q_valid,
  input  logic                q_pop
);
  import stip_pkg::*;

  localparam logic [FQ_PTR_BITS:0] CntFull = (FQ_PTR_BITS + 1)'(FQ_DEPTH);

  chr_info_t                info;
  chr_info_t                fq_mem_r [FQ_DEPTH];
  logic [FQ_PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FQ_PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FQ_PTR_BITS:0]     cnt_r, cnt_nxt;
  logic                     do_push;
  logic                     do_pop;
  logic [7:0]               c;

  always_comb begin
    c                 = in_item.char_code;
    info.new_string   = in_item.new_string;
    info.base_request = in_item.base_request;
    info.digit_ok     = 1'b0;
    info.digit        = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      info.digit_ok = 1'b1;
      info.digit    = 4'(c - CH_ZERO);
    end else if (c >= CH_LA && c <= CH_LF) begin
      info.digit_ok = 1'b1;
      info.digit    = 4'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UF) begin
      info.digit_ok = 1'b1;
      info.digit    = 4'(c - CH_UA + 8'd10);
    end
    info.is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    info.is_minus = (c == CH_MINUS);
    info.is_zero  = (c == CH_ZERO);
    info.is_x     = (c == CH_LX) || (c == CH_UX);
  end

  assign full    = (cnt_r == CntFull);
  assign q_valid = (cnt_r != '0);
  assign q_head  = fq_mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      fq_mem_r[wr_ptr_r] <= info;
    end
  end

endmodule

### src/stip_back.sv
// Parse engine: phase machine, multiply-add accumulator and result queue.
module stip_back #(
  parameter int COUNT_BITS = 16,
  parameter int VALUE_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stip_pkg::chr_info_t q_head,
  input  logic                q_valid,
  output logic                q_pop,
  output stip_pkg::out_item_t out_item,
  output logic                empty,
  input  logic                pop
);
  import stip_pkg::*;

  localparam logic [COUNT_BITS-1:0] CntMax = '1;
  localparam logic [RQ_PTR_BITS:0]  RqFull = (RQ_PTR_BITS + 1)'(RQ_DEPTH);

  phase_t                  phase_r, phase_nxt, ph_in;
  logic [VALUE_BITS-1:0]   acc_r, acc_nxt, acc_in;
  logic                    neg_r, neg_nxt, neg_in;
  logic [4:0]              base_r, base_nxt, base_in, base_eff;
  logic [COUNT_BITS-1:0]   cnt_r, cnt_nxt, cnt_in;
  logic [VALUE_BITS+4:0]   prod;
  logic [VALUE_BITS-1:0]   mac;
  logic [VALUE_BITS-1:0]   result_val;
  logic                    fire, lead, go_digit, count_inc, emit;
  out_item_t               res;

  out_item_t               rq_mem_r [RQ_DEPTH];
  logic [RQ_PTR_BITS-1:0]  rq_wr_r, rq_rd_r;
  logic [RQ_PTR_BITS:0]    rq_cnt_r;
  logic                    rq_pop;

  assign fire  = q_valid && (rq_cnt_r != RqFull);
  assign q_pop = fire;

  // A new string restarts the parse with this character.
  assign ph_in   = q_head.new_string ? PH_SPACE : phase_r;
  assign acc_in  = q_head.new_string ? '0 : acc_r;
  assign neg_in  = q_head.new_string ? 1'b0 : neg_r;
  assign base_in = q_head.new_string ? q_head.base_request : base_r;
  assign cnt_in  = q_head.new_string ? '0 : cnt_r;

  assign prod = acc_in * base_eff;
  assign mac  = prod[VALUE_BITS-1:0] + VALUE_BITS'(q_head.digit);

  assign result_val       = neg_in ? VALUE_BITS'(-acc_in) : acc_in;
  assign res.parsed_value = 64'(signed'(result_val));
  assign res.chars_used   = 16'(cnt_in);

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    base_nxt  = base_r;
    cnt_nxt   = cnt_r;
    base_eff  = base_in;
    lead      = 1'b0;
    go_digit  = 1'b0;
    count_inc = 1'b0;
    emit      = 1'b0;
    if (fire) begin
      phase_nxt = ph_in;
      acc_nxt   = acc_in;
      neg_nxt   = neg_in;
      base_nxt  = base_in;
      unique case (ph_in)
        PH_SPACE: begin
          if (q_head.is_space) begin
            count_inc = 1'b1;
          end else if (q_head.is_minus) begin
            neg_nxt   = 1'b1;
            count_inc = 1'b1;
            phase_nxt = PH_SIGNED;
          end else begin
            lead = 1'b1;
          end
        end
        PH_SIGNED: begin
          lead = 1'b1;
        end
        PH_ZERO: begin
          if (q_head.is_x) begin
            base_nxt  = BASE_HEX;
            count_inc = 1'b1;
            phase_nxt = PH_DIGITS;
          end else begin
            base_eff = BASE_OCT;
            go_digit = 1'b1;
          end
        end
        PH_DIGITS: begin
          go_digit = 1'b1;
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase

      // First character after any sign: a leading zero may open a prefix.
      if (lead) begin
        if (base_in == BASE_DETECT) begin
          if (q_head.is_zero) begin
            phase_nxt = PH_ZERO;
            count_inc = 1'b1;
          end else begin
            base_eff = BASE_DEC;
            go_digit = 1'b1;
          end
        end else begin
          go_digit = 1'b1;
        end
      end

      if (go_digit) begin
        base_nxt = base_eff;
        if (q_head.digit_ok && ({1'b0, q_head.digit} < base_eff)) begin
          acc_nxt   = mac;
          count_inc = 1'b1;
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = PH_DONE;
          emit      = 1'b1;
        end
      end

      cnt_nxt = (count_inc && cnt_in != CntMax) ? cnt_in + 1'b1 : cnt_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    neg_r  <= neg_nxt;
    base_r <= base_nxt;
    cnt_r  <= cnt_nxt;
  end

  // Result queue.
  assign empty    = (rq_cnt_r == '0);
  assign out_item = rq_mem_r[rq_rd_r];
  assign rq_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      if (emit) begin
        rq_wr_r <= rq_wr_r + 1'b1;
      end
      if (rq_pop) begin
        rq_rd_r <= rq_rd_r + 1'b1;
      end
      if (emit && !rq_pop) begin
        rq_cnt_r <= rq_cnt_r + 1'b1;
      end else if (rq_pop && !emit) begin
        rq_cnt_r <= rq_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rq_mem_r[rq_wr_r] <= res;
    end
  end

endmodule

### src/string_to_integer_parser.sv
// Top level of the streaming string-to-integer parser.
//
// The parser takes one character per transfer and returns one result for each string
// whose parse reaches a stopping character: the signed value and the count of characters
// consumed before the stopping character. It sustains one character per clock cycle while
// results are taken. A stopping character is first stored in the front queue at its input
// transfer, and the parse engine writes its result into the result queue when it takes the
// character from the front queue; out_item shows the oldest result in that queue. The rate
// of one character per cycle is set by the accumulator loop in the parse engine, which
// forms value * base + digit (a VALUE_BITS by 5-bit product and an add) combinationally
// for every digit. There is no clearing pass after reset.
module string_to_integer_parser #(
  parameter int COUNT_BITS = 16,
  parameter int VALUE_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stip_pkg::in_item_t  in_item,
  input  logic                push,
  output logic                full,
  output stip_pkg::out_item_t out_item,
  output logic                empty,
  input  logic                pop
);
  import stip_pkg::*;

  // Classified characters wait here between the front end and the parse engine.
  chr_info_t q_head;
  logic      q_valid;
  logic      q_pop;

  // The front end accepts a transfer whenever its short queue has room, so input
  // keeps flowing while a finished result waits to be popped.
  stip_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .push    (push),
    .full    (full),
    .q_head  (q_head),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // The parse engine consumes one queued character per cycle whenever its result
  // queue has room, and writes a result on the character that ends a parse.
  stip_back #(
    .COUNT_BITS (COUNT_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .out_item (out_item),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

### src/stip_checker.sv
// Port-level checks for the string-to-integer parser, bound to the top level.
module stip_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input stip_pkg::out_item_t out_item
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input side full after reset");

  a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push))
    else $error("full rose without an input transfer");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed or vanished");

endmodule

bind string_to_integer_parser stip_checker u_stip_checker (.*);

### bench/string_to_integer_parser_tb.sv
// Self-checking testbench for the streaming string-to-integer parser.
module string_to_integer_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stip_pkg::*;

  // Characters and bases used by the stimulus that the package does not name.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;
  localparam logic [7:0] CHAR_LG    = 8'h67;
  localparam logic [7:0] CHAR_HIGH  = 8'hFF;
  localparam logic [4:0] BASE_BIN   = 5'd2;
  localparam logic [4:0] BASE_UNARY = 5'd1;
  localparam logic [4:0] BASE_WIDE  = 5'd20;

  // Characters in the random part, trailing ones included.
  localparam int RANDOM_ITEMS = 1200;

  // Receiver hold-off windows, in cycles after reset. The sender keeps offering
  // characters during them, so both internal queues fill and full rises.
  localparam int HOLD_A_START = 400;
  localparam int HOLD_B_START = 1500;
  localparam int HOLD_LEN     = 300;

  // Cycles left for stray results after the last expected one has arrived.
  localparam int DRAIN_CYCLES = 16;

  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_HALF,
    POP_QUARTER,
    POP_MOSTLY
  } pop_style_t;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  in_item_t  in_item = '0;
  logic      push    = 1'b0;
  logic      full;
  out_item_t out_item;
  logic      empty;
  logic      pop     = 1'b0;

  string_to_integer_parser DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .push     (push),
    .full     (full),
    .out_item (out_item),
    .empty    (empty),
    .pop      (pop)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Characters waiting to be offered, and parse results owed by the block in order.
  in_item_t  char_stream[$];
  out_item_t due_parses[$];
  int        mismatch_count = 0;

  // Predictor state. The block is reset only once, so the initial values here
  // are the reset state: no string started, everything else zero.
  phase_t      pr_phase = PH_DONE;
  logic [63:0] pr_acc   = '0;
  logic        pr_neg   = 1'b0;
  logic [4:0]  pr_base  = '0;
  logic [15:0] pr_count = '0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // The consumed-character count sticks at its maximum.
  function automatic logic [15:0] count_up(input logic [15:0] n);
    return (n == 16'hFFFF) ? n : n + 16'd1;
  endfunction

  // Advances the predicted parse by one accepted character. When the character
  // stops the parse, the result it causes is queued.
  task automatic parse_char(input in_item_t it);
    logic [7:0] c;
    logic [4:0] dig;
    logic       dig_ok;
    out_item_t  res;
    c = it.char_code;
    if (it.new_string) begin
      pr_phase = PH_SPACE;
      pr_acc   = '0;
      pr_neg   = 1'b0;
      pr_count = '0;
      pr_base  = it.base_request;
    end
    if (pr_phase == PH_DONE) return;

    if (pr_phase == PH_SPACE) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        pr_count = count_up(pr_count);
        return;
      end
      pr_phase = PH_SIGNED;
      if (c == CH_MINUS) begin
        pr_neg   = 1'b1;
        pr_count = count_up(pr_count);
        return;
      end
    end
    if (pr_phase == PH_SIGNED) begin
      pr_phase = PH_DIGITS;
      if (pr_base == BASE_DETECT) begin
        if (c == CH_ZERO) begin
          pr_phase = PH_ZERO;
          pr_count = count_up(pr_count);
          return;
        end
        pr_base = BASE_DEC;
      end
    end
    if (pr_phase == PH_ZERO) begin
      // A leading zero in detect mode: an x makes it hex, anything else octal.
      pr_phase = PH_DIGITS;
      if (c == CH_LX || c == CH_UX) begin
        pr_base  = BASE_HEX;
        pr_count = count_up(pr_count);
        return;
      end
      pr_base = BASE_OCT;
    end

    dig_ok = 1'b1;
    dig    = '0;
    if (c >= CH_ZERO && c <= CH_NINE) dig = 5'(c - CH_ZERO);
    else if (c >= CH_LA && c <= CH_LF) dig = 5'(c - CH_LA) + 5'd10;
    else if (c >= CH_UA && c <= CH_UF) dig = 5'(c - CH_UA) + 5'd10;
    else dig_ok = 1'b0;
    if (dig_ok && dig < pr_base) begin
      pr_acc   = pr_acc * 64'(pr_base) + 64'(dig);
      pr_count = count_up(pr_count);
      return;
    end

    // Stopping character: emit the value, negated if a minus was seen.
    pr_phase         = PH_DONE;
    res.parsed_value = pr_neg ? (64'd0 - pr_acc) : pr_acc;
    res.chars_used   = pr_count;
    due_parses.push_back(res);
  endtask

  task automatic add_char(input logic [7:0] c, input logic first, input logic [4:0] b);
    char_stream.push_back('{char_code: c, new_string: first, base_request: b});
  endtask

  // Continuation character; its base field is ignored by the block, so it is random.
  task automatic add_next(input logic [7:0] c);
    add_char(c, 1'b0, 5'($urandom_range(0, 16)));
  endtask

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return CH_ZERO + 8'(d);
    return (($urandom_range(0, 1) == 0) ? CH_LA : CH_UA) + 8'(d - 10);
  endfunction

  // Queues one random string and reports how many characters it adds.
  // Most strings are well formed: whitespace, a sign, a prefix, digits of the base
  // and a terminator. Some drop the terminator so the next string restarts the
  // parse mid-number, some carry a plus or a second minus, and a few are noise.
  task automatic add_random_string(output int body_len);
    logic [7:0] text[$];
    logic [4:0] b;
    int         sel;
    int         radix;
    int         ndig;
    int         trail;
    sel = $urandom_range(0, 19);
    if (sel < 9) b = BASE_DETECT;
    else if (sel < 11) b = BASE_OCT;
    else if (sel < 13) b = BASE_DEC;
    else if (sel < 15) b = BASE_HEX;
    else if (sel == 15) b = BASE_UNARY;
    else if (sel == 16) b = BASE_BIN;
    else if (sel < 19) b = 5'($urandom_range(0, 16));
    else b = 5'($urandom_range(17, 31));

    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 5) == 0) text.push_back(CH_SPACE);
          else text.push_back(CH_TAB + 8'($urandom_range(0, 4)));
        end
      end
      sel = $urandom_range(0, 9);
      if (sel < 3) text.push_back(CH_MINUS);
      else if (sel == 3) text.push_back(CHAR_PLUS);
      else if (sel == 4) begin
        text.push_back(CH_MINUS);
        text.push_back(CH_MINUS);
      end

      // Digit range the body is drawn from, following the prefix in detect mode.
      if (b == BASE_DETECT) begin
        radix = 10;
        if ($urandom_range(0, 9) < 5) begin
          text.push_back(CH_ZERO);
          radix = 8;
          if ($urandom_range(0, 2) != 0) begin
            text.push_back(($urandom_range(0, 1) == 0) ? CH_LX : CH_UX);
            radix = 16;
          end
        end
      end else begin
        radix = (b > BASE_HEX) ? 16 : int'(b);
      end

      ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 6);
      repeat (ndig) begin
        if ($urandom_range(0, 15) == 0) text.push_back(digit_char($urandom_range(0, 15)));
        else text.push_back(digit_char($urandom_range(0, radix - 1)));
      end

      sel = $urandom_range(0, 9);
      if (sel < 4) text.push_back(8'($urandom_range(0, 255)));
      else if (sel == 4) text.push_back(CHAR_NUL);
      else if (sel == 5) text.push_back(CH_SPACE);
      else if (sel == 6) text.push_back(CHAR_COMMA);
      else if (sel < 9) text.push_back(CHAR_LG);
    end

    // A string with nothing drawn still needs a first character.
    if (text.size() == 0) text.push_back(CHAR_COMMA);

    add_char(text[0], 1'b1, b);
    for (int k = 1; k < text.size(); k++) add_next(text[k]);
    // Trailing characters the block should ignore once the parse has ended.
    trail = $urandom_range(0, 2);
    repeat (trail) add_next(8'($urandom_range(0, 255)));
    body_len = text.size() + trail;
  endtask

  // Sender. Characters go out in bursts of random length with random gaps in
  // between; a quarter of the bursts run back to back with no gap at all. The
  // prediction is made at the edge where the transfer happens.
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_chars
    logic next_push;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      next_push = push;
      if (push && !full) begin
        parse_char(in_item);
        next_push = 1'b0;
      end
      if (!next_push) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (char_stream.size() > 0) begin
          in_item   <= char_stream.pop_front();
          next_push = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      push <= next_push;
    end
  end

  // Cycle count after reset, kept apart from the receiver. It raises hold_off
  // for two long windows in which the receiver takes no results at all.
  int unsigned run_cycles = 0;
  logic        hold_off   = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      run_cycles <= 0;
      hold_off   <= 1'b0;
    end else begin
      run_cycles <= run_cycles + 1;
      hold_off   <= (run_cycles >= HOLD_A_START && run_cycles < HOLD_A_START + HOLD_LEN) ||
                    (run_cycles >= HOLD_B_START && run_cycles < HOLD_B_START + HOLD_LEN);
    end
  end

  // Receiver. Each result transfer is checked field by field against the oldest
  // owed result. The pop pattern switches among four styles at random intervals,
  // from taking every result to taking one in four.
  pop_style_t pop_style = POP_ALWAYS;
  int         style_left = 0;

  always @(posedge clk) begin : take_results
    out_item_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (due_parses.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %h count %0d",
                                    out_item.parsed_value, out_item.chars_used));
        end else begin
          want = due_parses.pop_front();
          if (out_item.parsed_value !== want.parsed_value)
            report_mismatch($sformatf("parsed_value %h, expected %h",
                                      out_item.parsed_value, want.parsed_value));
          if (out_item.chars_used !== want.chars_used)
            report_mismatch($sformatf("chars_used %0d, expected %0d",
                                      out_item.chars_used, want.chars_used));
        end
      end

      if (style_left == 0) begin
        pop_style  = pop_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(20, 80);
      end else begin
        style_left--;
      end

      if (hold_off) begin
        pop <= 1'b0;
      end else begin
        case (pop_style)
          POP_ALWAYS:  pop <= 1'b1;
          POP_HALF:    pop <= ($urandom_range(0, 1) == 0);
          POP_QUARTER: pop <= ($urandom_range(0, 3) == 0);
          default:     pop <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int body;
    int total;

    // Directed part. A character before any string has started is ignored.
    add_char(CHAR_HIGH, 1'b0, BASE_HEX);
    // Tab, minus, hex prefix in detect mode, upper-case digit, comma terminator.
    add_char(CH_TAB, 1'b1, BASE_DETECT);
    add_next(CH_MINUS);
    add_next(CH_ZERO);
    add_next(CH_LX);
    add_next(CHAR_ONE);
    add_next(CH_UF);
    add_next(CHAR_COMMA);
    // A 0X prefix with no hex digit after it: both consumed, value zero.
    add_char(CH_ZERO, 1'b1, BASE_DETECT);
    add_next(CH_UX);
    add_next(CHAR_LG);
    // Leading zero selects octal; the NUL character stops the parse.
    add_char(CH_ZERO, 1'b1, BASE_DETECT);
    add_next(CHAR_ONE);
    add_next(CHAR_SEVEN);
    add_next(CHAR_NUL);
    // With base 16 given, the x of a prefix stops the parse.
    add_char(CH_ZERO, 1'b1, BASE_HEX);
    add_next(CH_LX);
    // Base 1 takes only zeros.
    add_char(CH_ZERO, 1'b1, BASE_UNARY);
    add_next(CHAR_ONE);
    // A base above 16 takes every hex digit and nothing more.
    add_char(CH_LF, 1'b1, BASE_WIDE);
    add_next(CHAR_LG);
    // A lone minus is counted, and a second minus stops the parse.
    add_char(CH_MINUS, 1'b1, BASE_DEC);
    add_next(CH_MINUS);
    // A plus sign is not a sign at all; the high character after it is ignored.
    add_char(CHAR_PLUS, 1'b1, BASE_DEC);
    add_next(CHAR_HIGH);

    total = 0;
    while (total < RANDOM_ITEMS) begin
      add_random_string(body);
      total += body;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (char_stream.size() != 0 || push) @(posedge clk);
    while (due_parses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog. The stimulus holds about 1250 characters. Even if every one ended
  // a parse and the receiver took one result in four, with a sender gap on top
  // and the two hold-off windows, the run would stay below 0.2 ms. The limit
  // leaves a wide margin on that.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
src/stip_pkg.sv
src/stip_front.sv
src/stip_back.sv
src/string_to_integer_parser.sv
src/stip_checker.sv
bench/string_to_integer_parser_tb.sv
